FILE: sv/eft_pkg.sv
// ----------------------------------------------------------------------------
// eft_pkg
// shared constants, types and tables for the ellipse fan tessellator
// ----------------------------------------------------------------------------
package eft_pkg;

  localparam int IndexBits   = 16;
  localparam int CoordBits   = 24;
  localparam int MaxSegments = 31;
  localparam int CordicSteps = 20;
  localparam int StepBits    = 5;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_CENTER,
    ST_DIV,
    ST_ANG,
    ST_TRIG,
    ST_MUL_LX,
    ST_MUL_LY,
    ST_MUL_P1A,
    ST_MUL_P1B,
    ST_MUL_P2A,
    ST_MUL_P2B,
    ST_VERT,
    ST_TRI
  } state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                done;
    logic signed [33:0]  cos_v;
    logic signed [33:0]  sin_v;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_turn(input logic [StepBits-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2F9;
        5'd15: r = 32'h0000517C;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A2F;
        5'd19: r = 32'h00000517;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: sv/eft_cordic.sv
// ----------------------------------------------------------------------------
// eft_cordic
// iterative cordic, one micro-rotation per cycle, quadrant fold at the end
// ----------------------------------------------------------------------------
module eft_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eft_pkg::cordic_req_t req,
  output eft_pkg::cordic_rsp_t rsp
);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] z_r, z_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic [eft_pkg::StepBits-1:0] step_r, step_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    at = $signed({2'b00, eft_pkg::atan_turn(step_r)});
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; quad_nxt = quad_r;
    step_nxt = step_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      x_nxt = eft_pkg::CordicGain;
      y_nxt = '0;
      z_nxt = $signed({4'b0, req.angle[13:0], 16'b0});
      quad_nxt = req.angle[15:14];
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + at;
      end
      step_nxt = step_r + 1'b1;
      if (step_r == eft_pkg::StepBits'(eft_pkg::CordicSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; quad_r <= quad_nxt; step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    rsp.done = done_r;
    case (quad_r)
      2'd0: begin rsp.cos_v = x_r;  rsp.sin_v = y_r;  end
      2'd1: begin rsp.cos_v = -y_r; rsp.sin_v = x_r;  end
      2'd2: begin rsp.cos_v = -x_r; rsp.sin_v = -y_r; end
      default: begin rsp.cos_v = y_r; rsp.sin_v = -x_r; end
    endcase
  end

  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("cordic done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("cordic start lost");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r < eft_pkg::StepBits'(eft_pkg::CordicSteps))
    else $error("cordic step overrun");

endmodule

FILE: sv/ellipse_fan_tessellator_unit.sv
// ----------------------------------------------------------------------------
// ellipse_fan_tessellator_unit
// one ellipse in, centre vertex, rim vertices and fan triangles out
// ----------------------------------------------------------------------------
// order: centre vertex beat registered once the rotation cordic is done
// per rim vertex: angle division, cordic start, cordic,
//   6 steps on the one shared multiplier, output
// pacing: no new ellipse is taken until its last triangle beat is issued, plus output stalls;
//   a rejected ellipse is dropped while idle; the shared cordic and multiplier set the pace
// reset: synchronous active low, clears the running vertex count, fsm and out_valid
module ellipse_fan_tessellator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  input  logic signed [23:0] in_center_x,
  input  logic signed [23:0] in_center_y,
  input  logic signed [23:0] in_depth,
  input  logic [22:0]        in_axis_x,
  input  logic [22:0]        in_axis_y,
  input  logic [15:0]        in_rotation,
  input  logic [4:0]         in_segments,
  input  logic [31:0]        in_rgba,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_y,
  output logic signed [23:0] out_vert_z,
  output logic [31:0]        out_vert_rgba,
  output logic [15:0]        out_tri_a,
  output logic [15:0]        out_tri_b,
  output logic [15:0]        out_tri_c,
  output logic               out_last
);

  eft_pkg::state_t state_r, state_nxt;
  eft_pkg::cordic_req_t creq;
  eft_pkg::cordic_rsp_t crsp;

  logic [15:0] count_r, count_nxt, base_r, base_nxt;
  logic signed [23:0] cx_r, cy_r, cz_r;
  logic [22:0] rx_r, ry_r;
  logic [31:0] rgba_r;
  logic [4:0]  n_r, i_r, i_nxt;
  logic signed [33:0] cr_r, sr_r;
  logic signed [33:0] ct_r, st_r;
  logic [20:0] rem_r, rem_nxt;
  logic [15:0] q_r, q_nxt;
  logic [4:0]  dstep_r, dstep_nxt;
  logic signed [24:0] lx_r, ly_r;
  logic signed [63:0] p1_r, p2_r;
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_p;
  logic signed [63:0] prod, rnd_p;
  logic               ovalid_r, ovalid_nxt;
  logic               okind_r, olast_r;
  logic signed [23:0] ox_r, oy_r;
  logic [15:0]        ta_r, tb_r, tc_r;
  logic               accept, reject, out_free;
  logic [20:0]        rem_sh;
  logic signed [63:0] sx, sy;
  logic [4:0]         inext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != eft_pkg::ST_IDLE);
  assign reject   = (in_axis_x == '0) || (in_axis_y == '0) || (in_segments <= 5'd3);
  assign out_free = !ovalid_r || !out_stall;
  assign creq.start = (state_r == eft_pkg::ST_IDLE && accept && !reject)
                      || (state_r == eft_pkg::ST_ANG);
  assign creq.angle = (state_r == eft_pkg::ST_IDLE) ? in_rotation : q_r;
  assign rem_sh = {rem_r[19:0], 1'b0};
  assign inext  = (i_r == n_r - 5'd1) ? 5'd0 : i_r + 5'd1;

  eft_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    begin
      t = p + 64'sd536870912;
      return t >>> 30;
    end
  endfunction

  function automatic logic signed [23:0] sat(input logic signed [63:0] v);
    begin
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[23:0];
    end
  endfunction

  // single shared multiplier, operands chosen by state
  always_comb begin
    case (state_r)
      eft_pkg::ST_MUL_LX:  begin mul_a = ct_r; mul_b = $signed({2'b00, rx_r}); end
      eft_pkg::ST_MUL_LY:  begin mul_a = st_r; mul_b = $signed({2'b00, ry_r}); end
      eft_pkg::ST_MUL_P1A: begin mul_a = cr_r; mul_b = lx_r; end
      eft_pkg::ST_MUL_P1B: begin mul_a = sr_r; mul_b = ly_r; end
      eft_pkg::ST_MUL_P2A: begin mul_a = sr_r; mul_b = lx_r; end
      default:             begin mul_a = cr_r; mul_b = ly_r; end
    endcase
    mul_p = mul_a * mul_b;
    prod  = 64'(mul_p);
    rnd_p = rnd30(prod);
  end

  always_comb begin
    sx = rnd30(p1_r);
    sy = rnd30(p2_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      eft_pkg::ST_IDLE:    if (accept && !reject) state_nxt = eft_pkg::ST_ROT;
      eft_pkg::ST_ROT:     if (crsp.done) state_nxt = eft_pkg::ST_CENTER;
      eft_pkg::ST_CENTER:  if (out_free) state_nxt = eft_pkg::ST_DIV;
      eft_pkg::ST_DIV:     if (dstep_r == 5'd16) state_nxt = eft_pkg::ST_ANG;
      eft_pkg::ST_ANG:     state_nxt = eft_pkg::ST_TRIG;
      eft_pkg::ST_TRIG:    if (crsp.done) state_nxt = eft_pkg::ST_MUL_LX;
      eft_pkg::ST_MUL_LX:  state_nxt = eft_pkg::ST_MUL_LY;
      eft_pkg::ST_MUL_LY:  state_nxt = eft_pkg::ST_MUL_P1A;
      eft_pkg::ST_MUL_P1A: state_nxt = eft_pkg::ST_MUL_P1B;
      eft_pkg::ST_MUL_P1B: state_nxt = eft_pkg::ST_MUL_P2A;
      eft_pkg::ST_MUL_P2A: state_nxt = eft_pkg::ST_MUL_P2B;
      eft_pkg::ST_MUL_P2B: state_nxt = eft_pkg::ST_VERT;
      eft_pkg::ST_VERT: begin
        if (out_free) begin
          if (i_r == n_r - 5'd1) state_nxt = eft_pkg::ST_TRI;
          else state_nxt = eft_pkg::ST_DIV;
        end
      end
      eft_pkg::ST_TRI:
        if (out_free && i_r == n_r - 5'd1) state_nxt = eft_pkg::ST_IDLE;
      default: state_nxt = eft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r; base_nxt = base_r; i_nxt = i_r;
    rem_nxt = rem_r; q_nxt = q_r; dstep_nxt = dstep_r;
    ovalid_nxt = ovalid_r && out_stall;
    unique case (state_r)
      eft_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_restart) count_nxt = '0;
          base_nxt = in_restart ? '0 : count_r;
          i_nxt = '0;
        end
      end
      eft_pkg::ST_CENTER: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          rem_nxt = '0; q_nxt = '0; dstep_nxt = '0;
        end
      end
      eft_pkg::ST_DIV: begin
        // restoring division of i*65536 by n, one quotient bit per cycle
        if (dstep_r == 5'd0) begin
          rem_nxt = {16'b0, i_r};
        end else begin
          if (rem_sh >= {16'b0, n_r}) begin
            rem_nxt = rem_sh - {16'b0, n_r};
            q_nxt = {q_r[14:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            q_nxt = {q_r[14:0], 1'b0};
          end
        end
        dstep_nxt = dstep_r + 5'd1;
      end
      eft_pkg::ST_VERT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          rem_nxt = '0; q_nxt = '0; dstep_nxt = '0;
          i_nxt = inext;
        end
      end
      eft_pkg::ST_TRI: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          i_nxt = i_r + 5'd1;
          if (i_r == n_r - 5'd1) count_nxt = base_r + 16'(n_r) + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == eft_pkg::ST_IDLE && accept) begin
      cx_r <= in_center_x; cy_r <= in_center_y; cz_r <= in_depth;
      rx_r <= in_axis_x; ry_r <= in_axis_y; rgba_r <= in_rgba; n_r <= in_segments;
    end
    if (state_r == eft_pkg::ST_ROT && crsp.done) begin
      cr_r <= crsp.cos_v; sr_r <= crsp.sin_v;
    end
    if (state_r == eft_pkg::ST_TRIG && crsp.done) begin
      ct_r <= crsp.cos_v; st_r <= crsp.sin_v;
    end
    // local point, then rotated offset accumulated over the shared multiplier
    case (state_r)
      eft_pkg::ST_MUL_LX:  lx_r <= rnd_p[24:0];
      eft_pkg::ST_MUL_LY:  ly_r <= rnd_p[24:0];
      eft_pkg::ST_MUL_P1A: p1_r <= prod;
      eft_pkg::ST_MUL_P1B: p1_r <= p1_r - prod;
      eft_pkg::ST_MUL_P2A: p2_r <= prod;
      eft_pkg::ST_MUL_P2B: p2_r <= p2_r + prod;
      default: ;
    endcase
    if (out_free) begin
      if (state_r == eft_pkg::ST_CENTER) begin
        okind_r <= 1'b0; ox_r <= cx_r; oy_r <= cy_r; olast_r <= 1'b0;
        ta_r <= '0; tb_r <= '0; tc_r <= '0;
      end else if (state_r == eft_pkg::ST_VERT) begin
        okind_r <= 1'b0; olast_r <= 1'b0;
        ox_r <= sat(64'(cx_r) + sx); oy_r <= sat(64'(cy_r) + sy);
        ta_r <= '0; tb_r <= '0; tc_r <= '0;
      end else if (state_r == eft_pkg::ST_TRI) begin
        okind_r <= 1'b1; ox_r <= '0; oy_r <= '0;
        olast_r <= (i_r == n_r - 5'd1);
        ta_r <= base_r;
        tb_r <= base_r + 16'd1 + 16'(inext);
        tc_r <= base_r + 16'd1 + 16'(i_r);
      end
    end
    rem_r <= rem_nxt; q_r <= q_nxt; dstep_r <= dstep_nxt; base_r <= base_nxt; i_r <= i_nxt;
    if (!rst_n) begin
      state_r <= eft_pkg::ST_IDLE;
      count_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid     = ovalid_r;
  assign out_kind      = okind_r;
  assign out_vert_x    = ox_r;
  assign out_vert_y    = oy_r;
  assign out_vert_z    = okind_r ? 24'sd0 : cz_r;
  assign out_vert_rgba = okind_r ? 32'd0 : rgba_r;
  assign out_tri_a     = ta_r;
  assign out_tri_b     = tb_r;
  assign out_tri_c     = tc_r;
  assign out_last      = olast_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("beat dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_stall |=> !out_valid) else $error("beat after last");
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == eft_pkg::ST_IDLE) else $error("accept while busy");

endmodule

FILE: test/ellipse_fan_tessellator_unit_tb.sv
// ----------------------------------------------------------------------------
// ellipse_fan_tessellator_unit_tb
// drives ellipses through the tessellator with random gaps and stalls and
// compares every vertex and triangle beat against a local fixed-point predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ellipse_fan_tessellator_unit_tb;

  typedef struct packed {
    logic               restart;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] depth;
    logic [22:0]        axis_x;
    logic [22:0]        axis_y;
    logic [15:0]        rotation;
    logic [4:0]         segments;
    logic [31:0]        rgba;
  } ellipse_t;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic [31:0]        rgba;
    logic [15:0]        a;
    logic [15:0]        b;
    logic [15:0]        c;
    logic               last;
  } record_t;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_fire;
  ellipse_t in_item;
  logic out_valid;
  logic out_stall;
  record_t got;

  ellipse_t pending_ellipses[$];
  record_t  expected_records[$];
  logic [15:0] running_count;
  int errors;
  int stall_hold;
  bit hold_done;
  bit stim_done;

  ellipse_fan_tessellator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_restart(in_item.restart), .in_center_x(in_item.center_x),
    .in_center_y(in_item.center_y), .in_depth(in_item.depth),
    .in_axis_x(in_item.axis_x), .in_axis_y(in_item.axis_y),
    .in_rotation(in_item.rotation), .in_segments(in_item.segments),
    .in_rgba(in_item.rgba),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(got.kind), .out_vert_x(got.vx), .out_vert_y(got.vy),
    .out_vert_z(got.vz), .out_vert_rgba(got.rgba), .out_tri_a(got.a),
    .out_tri_b(got.b), .out_tri_c(got.c), .out_last(got.last)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint asr_l(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_q30(longint p);
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [23:0] clamp_coord(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  task automatic cordic_sincos(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic [1:0] quad;
    x = eft_pkg::CordicGain;
    y = 0;
    quad = ang[15:14];
    z = longint'({ang[13:0], 16'h0});
    for (int i = 0; i < eft_pkg::CordicSteps; i++) begin
      dx = asr_l(y, i);
      dy = asr_l(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(eft_pkg::atan_turn(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(eft_pkg::atan_turn(i[4:0]));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic tessellate(input ellipse_t e);
    longint cr, sr, ct, st, lx, ly, ox, oy, rx, ry;
    int n;
    logic [15:0] base;
    record_t r;
    if (e.restart) running_count = '0;
    n = int'(e.segments);
    if (n > eft_pkg::MaxSegments) n = eft_pkg::MaxSegments;
    if (e.axis_x == 0 || e.axis_y == 0 || n <= 3) return;
    base = running_count;
    rx = longint'(e.axis_x);
    ry = longint'(e.axis_y);
    cordic_sincos(e.rotation, cr, sr);
    r = '0;
    r.kind = KIND_VERTEX;
    r.vx = e.center_x; r.vy = e.center_y; r.vz = e.depth; r.rgba = e.rgba;
    expected_records.push_back(r);
    for (int i = 0; i < n; i++) begin
      cordic_sincos(16'((i * 65536) / n), ct, st);
      lx = round_q30(rx * ct);
      ly = round_q30(ry * st);
      ox = round_q30(lx * cr - ly * sr);
      oy = round_q30(lx * sr + ly * cr);
      r.vx = clamp_coord(longint'(e.center_x) + ox);
      r.vy = clamp_coord(longint'(e.center_y) + oy);
      expected_records.push_back(r);
    end
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.kind = KIND_TRI;
      r.a = base;
      r.b = base + 16'(1 + ((i + 1) % n));
      r.c = base + 16'(1 + i);
      r.last = (i + 1 == n);
      expected_records.push_back(r);
    end
    running_count = base + 16'(n + 1);
  endtask

  task automatic report(input string what, input record_t g, input record_t e);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, g, e, $realtime);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // input beat taken at the clock edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // driver
  int in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (in_fire) begin
      tessellate(in_item);
      in_gap = gap_len();
      if (in_gap == 0 && pending_ellipses.size() > 0) begin
        in_item <= pending_ellipses.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) in_gap--;
      else if (pending_ellipses.size() > 0) begin
        in_item <= pending_ellipses.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
      out_stall <= 1'b1;
    end else if (!hold_done && expected_records.size() > 20) begin
      hold_done = 1'b1;
      stall_hold = 3000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : ($urandom_range(0, 99) < 3);
    end
  end

  // monitor
  always @(posedge clk) begin
    record_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        report("unexpected beat", got, '0);
      end else begin
        e = expected_records.pop_front();
        if (got.kind !== e.kind) report("kind", got, e);
        if (got.vx !== e.vx) report("vert_x", got, e);
        if (got.vy !== e.vy) report("vert_y", got, e);
        if (got.vz !== e.vz) report("vert_z", got, e);
        if (got.rgba !== e.rgba) report("vert_rgba", got, e);
        if (got.a !== e.a) report("tri_a", got, e);
        if (got.b !== e.b) report("tri_b", got, e);
        if (got.c !== e.c) report("tri_c", got, e);
        if (got.last !== e.last) report("last", got, e);
      end
    end
  end

  function automatic ellipse_t rand_ellipse();
    ellipse_t e;
    int p;
    e.restart  = ($urandom_range(0, 15) == 0);
    e.center_x = 24'($urandom);
    e.center_y = 24'($urandom);
    e.depth    = 24'($urandom);
    e.rotation = 16'($urandom);
    e.rgba     = $urandom;
    p = $urandom_range(0, 9);
    e.axis_x = (p < 3) ? 23'($urandom_range(1, 4096)) : 23'($urandom);
    e.axis_y = (p < 3) ? 23'($urandom_range(1, 4096)) : 23'($urandom);
    e.segments = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(4, 12)) : 5'($urandom);
    p = $urandom_range(0, 19);
    if (p == 0) e.axis_x = '0;
    if (p == 1) e.axis_y = '0;
    if (p == 2) e.segments = 5'($urandom_range(0, 3));
    return e;
  endfunction

  initial begin
    ellipse_t e;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_item = '0;
    running_count = '0;
    errors = 0;
    stall_hold = 0;
    hold_done = 1'b0;
    stim_done = 1'b0;

    // directed: extremes, rejections, segment limits, saturation, wrap
    e = '0; e.axis_x = 23'h7fffff; e.axis_y = 23'h7fffff; e.segments = 5'd4;
    e.center_x = 24'sh7fffff; e.center_y = 24'sh800000; e.depth = 24'sh7fffff;
    e.rgba = 32'hffffffff;
    pending_ellipses.push_back(e);
    e.center_x = 24'sh800000; e.center_y = 24'sh7fffff; e.depth = 24'sh800000;
    e.rotation = 16'hffff; e.segments = 5'd31; e.rgba = '0;
    pending_ellipses.push_back(e);
    e.axis_x = 23'd1; e.axis_y = 23'd1; e.rotation = 16'h4000; e.segments = 5'd5;
    e.center_x = '0; e.center_y = '0;
    pending_ellipses.push_back(e);
    e.axis_x = '0; pending_ellipses.push_back(e);
    e.axis_x = 23'd256; e.axis_y = '0; pending_ellipses.push_back(e);
    for (int s = 0; s <= 3; s++) begin
      e.axis_y = 23'd256; e.segments = 5'(s); pending_ellipses.push_back(e);
    end
    e.restart = 1'b1; e.segments = 5'd3; pending_ellipses.push_back(e);
    e.restart = 1'b1; e.segments = 5'd6; e.rotation = 16'h8000;
    pending_ellipses.push_back(e);
    e.restart = 1'b0; e.rotation = 16'hc000; e.segments = 5'd7;
    e.axis_x = 23'h400000; e.axis_y = 23'd3;
    pending_ellipses.push_back(e);
    // a run of 31-segment fans without restart builds up the running vertex count
    for (int i = 0; i < 450; i++) begin
      e = rand_ellipse();
      if (i > 300 && i < 340) begin
        e.restart = 1'b0; e.segments = 5'd31; e.axis_x = 23'd100; e.axis_y = 23'd50;
      end
      pending_ellipses.push_back(e);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_ellipses.size() == 0 && !in_valid);
    wait (expected_records.size() == 0);
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
